// File: hw/rtl/sram_puf_seed_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the seed tracker RTL.
// Both macros check on the rising clock and are quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef SRAM_PUF_SEED_TRACKER_ASSERT_SVH
`define SRAM_PUF_SEED_TRACKER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and helper functions for the SRAM power-up seed tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sps_pkg;

   // Sizes
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 10;
   localparam int CRC_W  = 16;
   localparam int POP_W  = 4;

   // Run size used by the ok flag
   localparam int RUN_BYTES = 64;

   // CRC-16/CCITT-FALSE
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MODE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_HISTORY = 1'b1;

   // Input item
   typedef struct packed {
      logic [BYTE_W-1:0] sram_byte;
      logic [BYTE_W-1:0] stored_key_byte;
      logic [BYTE_W-1:0] stored_mask_byte;
      logic              last;
   } req_type;

   // Result item
   typedef struct packed {
      logic [BYTE_W-1:0] new_key_byte;
      logic [BYTE_W-1:0] new_mask_byte;
      logic [BYTE_W-1:0] new_masked_byte;
      logic [CNT_W-1:0]  raw_ones;
      logic [CNT_W-1:0]  saved_ones;
      logic [CNT_W-1:0]  mask_ones;
      logic [CNT_W-1:0]  key_ones;
      logic [CRC_W-1:0]  seed;
      logic              seed_ok;
      logic              run_end;
   } rsp_type;

   // Number of set bits in a byte
   function automatic logic [POP_W-1:0] pop8(input logic [BYTE_W-1:0] v);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + POP_W'(v[i]);
      end
      return n;
   endfunction

   // Add a byte count to a running count, holding at all ones
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                input logic [POP_W-1:0] add);
      logic [CNT_W:0] s;
      s = {1'b0, acc} + (CNT_W+1)'(add);
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

   // One byte of CRC-16/CCITT-FALSE, MSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/sps_stream_if.sv
// ----------------------------------------------------------------------------
// sps_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sps_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sram_puf_seed_tracker.sv
// ----------------------------------------------------------------------------
// sram_puf_seed_tracker
// Items pass through the input register, then the result register; a stalled
// result register holds the input register. Throughput: one item per cycle
// while the result side is not stalled, set by the combinational CRC byte
// update and popcounts between the input register and the result register.
// Reset (synchronous, active high) empties both stages, zeroes the counts and
// config, and loads both CRCs with 0xFFFF.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sram_puf_seed_tracker_assert.svh"

module sram_puf_seed_tracker (
   input  logic                          clock,
   input  logic                          reset,
   sps_stream_if.sink                    req_if,
   sps_stream_if.source                  rsp_if,
   input  logic                          csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                          csr_wdata
);

   // Configuration registers
   logic key_mode_ff;
   logic clear_history_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff      <= 1'b0;
         clear_history_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            sps_pkg::CSR_KEY_MODE:      key_mode_ff      <= csr_wdata;
            sps_pkg::CSR_CLEAR_HISTORY: clear_history_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage control
   logic             s1_valid_ff, s1_valid_in;
   sps_pkg::req_type s1_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   sps_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             s1_adv;
   logic             req_take;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   // Running state
   logic [sps_pkg::CNT_W-1:0] raw_cnt_ff,   raw_cnt_in;
   logic [sps_pkg::CNT_W-1:0] saved_cnt_ff, saved_cnt_in;
   logic [sps_pkg::CNT_W-1:0] mask_cnt_ff,  mask_cnt_in;
   logic [sps_pkg::CNT_W-1:0] key_cnt_ff,   key_cnt_in;
   logic [sps_pkg::CRC_W-1:0] crc_raw_ff,   crc_raw_in;
   logic [sps_pkg::CRC_W-1:0] crc_mask_ff,  crc_mask_in;

   // Per-item compute
   logic [sps_pkg::BYTE_W-1:0] nmask;
   logic [sps_pkg::BYTE_W-1:0] masked;
   logic [sps_pkg::CNT_W-1:0]  raw_nx, saved_nx, mask_nx, key_nx;
   logic [sps_pkg::CRC_W-1:0]  crc_raw_nx, crc_mask_nx;

   always_comb begin
      nmask  = s1_data_ff.stored_mask_byte
             | (s1_data_ff.sram_byte ^ s1_data_ff.stored_key_byte);
      masked = s1_data_ff.sram_byte & ~nmask;

      raw_nx   = sps_pkg::sat_add(raw_cnt_ff,   sps_pkg::pop8(s1_data_ff.sram_byte));
      saved_nx = sps_pkg::sat_add(saved_cnt_ff, sps_pkg::pop8(s1_data_ff.stored_key_byte));
      mask_nx  = sps_pkg::sat_add(mask_cnt_ff,  sps_pkg::pop8(nmask));
      key_nx   = sps_pkg::sat_add(key_cnt_ff,   sps_pkg::pop8(masked));

      crc_raw_nx  = sps_pkg::crc_byte(crc_raw_ff,  s1_data_ff.sram_byte);
      crc_mask_nx = sps_pkg::crc_byte(crc_mask_ff, masked);

      // Result fields
      rsp_data_in.new_key_byte    = s1_data_ff.sram_byte;
      rsp_data_in.new_mask_byte   = clear_history_ff ? '0 : nmask;
      rsp_data_in.new_masked_byte = clear_history_ff ? '0 : masked;
      rsp_data_in.raw_ones        = raw_nx;
      rsp_data_in.saved_ones      = saved_nx;
      rsp_data_in.mask_ones       = mask_nx;
      rsp_data_in.key_ones        = key_nx;
      rsp_data_in.seed            = clear_history_ff ? '0
                                  : (key_mode_ff ? crc_mask_nx : crc_raw_nx);
      rsp_data_in.seed_ok         = ({1'b0, raw_nx} > (sps_pkg::CNT_W+1)'(sps_pkg::RUN_BYTES));
      rsp_data_in.run_end         = s1_data_ff.last;

      // State update; the last item of a run restarts it
      raw_cnt_in   = raw_cnt_ff;
      saved_cnt_in = saved_cnt_ff;
      mask_cnt_in  = mask_cnt_ff;
      key_cnt_in   = key_cnt_ff;
      crc_raw_in   = crc_raw_ff;
      crc_mask_in  = crc_mask_ff;
      if (s1_adv) begin
         if (s1_data_ff.last) begin
            raw_cnt_in   = '0;
            saved_cnt_in = '0;
            mask_cnt_in  = '0;
            key_cnt_in   = '0;
            crc_raw_in   = sps_pkg::CRC_INIT;
            crc_mask_in  = sps_pkg::CRC_INIT;
         end else begin
            raw_cnt_in   = raw_nx;
            saved_cnt_in = saved_nx;
            mask_cnt_in  = mask_nx;
            key_cnt_in   = key_nx;
            crc_raw_in   = crc_raw_nx;
            crc_mask_in  = crc_mask_nx;
         end
      end
   end

   // Control and running state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         raw_cnt_ff   <= '0;
         saved_cnt_ff <= '0;
         mask_cnt_ff  <= '0;
         key_cnt_ff   <= '0;
         crc_raw_ff   <= sps_pkg::CRC_INIT;
         crc_mask_ff  <= sps_pkg::CRC_INIT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         raw_cnt_ff   <= raw_cnt_in;
         saved_cnt_ff <= saved_cnt_in;
         mask_cnt_ff  <= mask_cnt_in;
         key_cnt_ff   <= key_cnt_in;
         crc_raw_ff   <= crc_raw_in;
         crc_mask_ff  <= crc_mask_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_if.data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks
   `SPS_ASSERT_NEXT(a_run_restart, clock, reset, s1_adv && s1_data_ff.last,
      raw_cnt_ff == '0 && key_cnt_ff == '0 && crc_raw_ff == sps_pkg::CRC_INIT)
   `SPS_ASSERT_NOW(a_masked_disjoint, clock, reset, rsp_valid_ff,
      (rsp_data_ff.new_mask_byte & rsp_data_ff.new_masked_byte) == '0)
   `SPS_ASSERT_NOW(a_seed_ok, clock, reset, rsp_valid_ff,
      rsp_data_ff.seed_ok ==
      ({1'b0, rsp_data_ff.raw_ones} > (sps_pkg::CNT_W+1)'(sps_pkg::RUN_BYTES)))
   `SPS_ASSERT_NEXT(a_count_grows, clock, reset, s1_adv && !s1_data_ff.last,
      raw_cnt_ff >= $past(raw_cnt_ff) && mask_cnt_ff >= $past(mask_cnt_ff))

endmodule

// File: tb/sram_puf_seed_tracker_tb.sv
// ----------------------------------------------------------------------------
// sram_puf_seed_tracker_tb
// Self-checking bench for the SRAM power-up seed tracker. Items are driven
// over the request channel and each write-back result is checked field by
// field against an in-bench copy of the tracker: saturating ones-counts,
// raw and masked CRC-16/CCITT-FALSE, mask update and seed selection.
// Covers directed corner bytes, count saturation, random runs under several
// idle/stall mixes with mode changes, and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sram_puf_seed_tracker_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_SHOWN      = 10;
   localparam int HOLD_CYCLES    = 300;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [sps_pkg::CSR_IDX_W-1:0] csr_index;
   logic csr_wdata;

   sps_stream_if #(.payload_type(sps_pkg::req_type)) req_ch ();
   sps_stream_if #(.payload_type(sps_pkg::rsp_type)) rsp_ch ();

   sram_puf_seed_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle mix of both sides, in percent of cycles
   int tx_idle_pct;
   int rx_stall_pct;

   // Long output hold-off, requested by bumping hold_seq
   int hold_len;
   int hold_seq;

   // Mirror of the tracker: mode registers and running state
   logic                      cfg_key_mode;
   logic                      cfg_clear_history;
   logic [sps_pkg::CNT_W-1:0] raw_total;
   logic [sps_pkg::CNT_W-1:0] saved_total;
   logic [sps_pkg::CNT_W-1:0] mask_total;
   logic [sps_pkg::CNT_W-1:0] kept_total;
   logic [sps_pkg::CRC_W-1:0] crc_raw;
   logic [sps_pkg::CRC_W-1:0] crc_kept;

   sps_pkg::rsp_type seed_results_due[$];
   int               fault_count;
   int               quiet_cycles;

   // Count add that holds at all ones
   function automatic logic [sps_pkg::CNT_W-1:0] add_capped(
      input logic [sps_pkg::CNT_W-1:0] acc, input int add);
      int sum;
      sum = int'(acc) + add;
      return (sum > (1 << sps_pkg::CNT_W) - 1) ? {sps_pkg::CNT_W{1'b1}}
                                               : sps_pkg::CNT_W'(sum);
   endfunction

   // Bitwise CRC-16 (poly 0x1021), byte fed MSB first
   function automatic logic [sps_pkg::CRC_W-1:0] crc16_feed(
      input logic [sps_pkg::CRC_W-1:0] crc, input logic [sps_pkg::BYTE_W-1:0] b);
      logic [sps_pkg::CRC_W-1:0] c;
      logic fb;
      c = crc;
      for (int i = sps_pkg::BYTE_W - 1; i >= 0; i--) begin
         fb = c[sps_pkg::CRC_W-1] ^ b[i];
         c  = {c[sps_pkg::CRC_W-2:0], 1'b0} ^ (fb ? sps_pkg::CRC_POLY : '0);
      end
      return c;
   endfunction

   function automatic void clear_run_state();
      raw_total   = '0;
      saved_total = '0;
      mask_total  = '0;
      kept_total  = '0;
      crc_raw     = sps_pkg::CRC_INIT;
      crc_kept    = sps_pkg::CRC_INIT;
   endfunction

   // Advance the mirrored state by one byte and give its write-back result
   function automatic sps_pkg::rsp_type track_sram_byte(input sps_pkg::req_type item);
      sps_pkg::rsp_type r;
      logic [sps_pkg::BYTE_W-1:0] upd_mask;
      logic [sps_pkg::BYTE_W-1:0] kept;
      upd_mask    = item.stored_mask_byte | (item.sram_byte ^ item.stored_key_byte);
      kept        = item.sram_byte & ~upd_mask;
      raw_total   = add_capped(raw_total, $countones(item.sram_byte));
      saved_total = add_capped(saved_total, $countones(item.stored_key_byte));
      mask_total  = add_capped(mask_total, $countones(upd_mask));
      kept_total  = add_capped(kept_total, $countones(kept));
      crc_raw     = crc16_feed(crc_raw, item.sram_byte);
      crc_kept    = crc16_feed(crc_kept, kept);

      r.new_key_byte    = item.sram_byte;
      r.new_mask_byte   = cfg_clear_history ? '0 : upd_mask;
      r.new_masked_byte = cfg_clear_history ? '0 : kept;
      r.raw_ones        = raw_total;
      r.saved_ones      = saved_total;
      r.mask_ones       = mask_total;
      r.key_ones        = kept_total;
      r.seed            = cfg_clear_history ? '0 : (cfg_key_mode ? crc_kept : crc_raw);
      r.seed_ok         = (int'(raw_total) > sps_pkg::RUN_BYTES);
      r.run_end         = item.last;

      // last byte closes the run
      if (item.last) begin
         clear_run_state();
      end
      return r;
   endfunction

   function automatic sps_pkg::req_type make_item(input logic [7:0] s,
                                                  input logic [7:0] k,
                                                  input logic [7:0] m, input logic l);
      sps_pkg::req_type r;
      r.sram_byte        = s;
      r.stored_key_byte  = k;
      r.stored_mask_byte = m;
      r.last             = l;
      return r;
   endfunction

   // Random byte: mostly a key close to the SRAM byte, sometimes pure noise
   function automatic sps_pkg::req_type random_byte(input bit dense);
      sps_pkg::req_type r;
      r.sram_byte = dense ? sps_pkg::BYTE_W'($urandom | $urandom)
                          : sps_pkg::BYTE_W'($urandom);
      case ($urandom_range(4))
         0:       r.stored_key_byte = r.sram_byte;
         1:       r.stored_key_byte = r.sram_byte
                                    ^ sps_pkg::BYTE_W'(1 << $urandom_range(7));
         2:       r.stored_key_byte = r.sram_byte
                                    ^ sps_pkg::BYTE_W'($urandom & $urandom & $urandom);
         default: r.stored_key_byte = sps_pkg::BYTE_W'($urandom);
      endcase
      case ($urandom_range(3))
         0:       r.stored_mask_byte = '0;
         1:       r.stored_mask_byte = sps_pkg::BYTE_W'($urandom & $urandom & $urandom);
         2:       r.stored_mask_byte = sps_pkg::BYTE_W'($urandom);
         default: r.stored_mask_byte = dense ? 8'hFF
                                             : sps_pkg::BYTE_W'($urandom | $urandom);
      endcase
      r.last = 1'b0;
      return r;
   endfunction

   task automatic show_mismatch(input string what, input sps_pkg::rsp_type want,
                                input sps_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= MAX_SHOWN) begin
         $display("%0t: %s", $realtime, what);
         $display("  exp key=%h mask=%h masked=%h ones=%0d/%0d/%0d/%0d seed=%h ok=%b end=%b",
                  want.new_key_byte, want.new_mask_byte, want.new_masked_byte,
                  want.raw_ones, want.saved_ones, want.mask_ones, want.key_ones,
                  want.seed, want.seed_ok, want.run_end);
         $display("  got key=%h mask=%h masked=%h ones=%0d/%0d/%0d/%0d seed=%h ok=%b end=%b",
                  got.new_key_byte, got.new_mask_byte, got.new_masked_byte,
                  got.raw_ones, got.saved_ones, got.mask_ones, got.key_ones,
                  got.seed, got.seed_ok, got.run_end);
      end
   endtask

   // Check each result, then predict for each accepted item
   always @(posedge clock) begin : check_results
      sps_pkg::rsp_type want;
      sps_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (seed_results_due.size() == 0) begin
               show_mismatch("result with no item pending", '0, got);
            end else begin
               want = seed_results_due.pop_front();
               if (got.new_key_byte    !== want.new_key_byte    ||
                   got.new_mask_byte   !== want.new_mask_byte   ||
                   got.new_masked_byte !== want.new_masked_byte ||
                   got.raw_ones        !== want.raw_ones        ||
                   got.saved_ones      !== want.saved_ones      ||
                   got.mask_ones       !== want.mask_ones       ||
                   got.key_ones        !== want.key_ones        ||
                   got.seed            !== want.seed            ||
                   got.seed_ok         !== want.seed_ok         ||
                   got.run_end         !== want.run_end) begin
                  show_mismatch("result mismatch", want, got);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seed_results_due.push_back(track_sram_byte(req_ch.data));
         end
      end
   end

   // Watchdog: too long with nothing accepted on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Output side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin : drive_rsp_ready
      int hold_seen;
      int hold_left;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Offer one item after a random gap; returns at the accepting edge
   task automatic send_byte(input sps_pkg::req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      @(negedge clock);
      while (gap > 0) begin
         req_ch.valid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every result is back
   task automatic drain_tracker();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (seed_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sps_pkg::CSR_IDX_W-1:0] idx, input logic val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == sps_pkg::CSR_KEY_MODE) begin
         cfg_key_mode = val;
      end else begin
         cfg_clear_history = val;
      end
   endtask

   // Mode change only once the pipeline is empty
   task automatic set_mode(input logic key_mode, input logic clear_history);
      drain_tracker();
      write_csr(sps_pkg::CSR_KEY_MODE, key_mode);
      write_csr(sps_pkg::CSR_CLEAR_HISTORY, clear_history);
   endtask

   task automatic send_random_run(input int run_len, input bit dense, input bit close_run);
      sps_pkg::req_type item;
      for (int n = 0; n < run_len; n++) begin
         item      = random_byte(dense);
         item.last = close_run && (n == run_len - 1);
         send_byte(item);
      end
   endtask

   // Corner bytes, both key modes, clear mode, mid-run changes, ok threshold
   task automatic test_directed();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      set_mode(1'b0, 1'b0);
      send_byte(make_item(8'h00, 8'h00, 8'h00, 1'b0));
      send_byte(make_item(8'hFF, 8'hFF, 8'h00, 1'b0));
      send_byte(make_item(8'hFF, 8'h00, 8'h00, 1'b0));
      send_byte(make_item(8'h00, 8'hFF, 8'h00, 1'b0));
      send_byte(make_item(8'hAA, 8'h55, 8'h00, 1'b0));
      send_byte(make_item(8'h55, 8'h55, 8'hFF, 1'b1));

      // seed from the masked CRC
      set_mode(1'b1, 1'b0);
      send_byte(make_item(8'hFF, 8'hFF, 8'h00, 1'b0));
      send_byte(make_item(8'hA5, 8'hA5, 8'h0F, 1'b0));
      send_byte(make_item(8'h80, 8'h01, 8'h00, 1'b0));
      send_byte(make_item(8'h7E, 8'h7E, 8'h81, 1'b1));

      // clear mode: counts and CRCs keep running, mask write-back and seed zero
      set_mode(1'b1, 1'b1);
      send_byte(make_item(8'hFF, 8'hFE, 8'h00, 1'b0));
      send_byte(make_item(8'h3C, 8'h3C, 8'h00, 1'b0));
      set_mode(1'b0, 1'b1);
      send_byte(make_item(8'hC3, 8'hC3, 8'h00, 1'b0));
      set_mode(1'b0, 1'b0);
      send_byte(make_item(8'hF0, 8'h0F, 8'h00, 1'b0));
      send_byte(make_item(8'h01, 8'h01, 8'h00, 1'b1));

      // one-byte run
      send_byte(make_item(8'hFF, 8'hFF, 8'h00, 1'b1));

      // ok flag: 64 raw ones is not enough, 65 is
      for (int n = 0; n < 8; n++) begin
         send_byte(make_item(8'hFF, 8'hFF, 8'h00, 1'b0));
      end
      send_byte(make_item(8'h01, 8'h01, 8'h00, 1'b1));
   endtask

   // Every count runs into its ceiling within one long run
   task automatic test_count_saturation();
      tx_idle_pct  = 12;
      rx_stall_pct = 12;
      set_mode(1'b1, 1'b0);
      for (int n = 0; n < 130; n++) begin
         send_byte(make_item(8'hFF, 8'hFF, 8'h00, 1'b0));
      end
      for (int n = 0; n < 130; n++) begin
         send_byte(make_item(8'hFF, 8'h00, 8'hFF, n == 129));
      end
   endtask

   // Random runs under each idle mix, modes changed between and inside runs
   task automatic test_random_runs();
      int  sent;
      int  since_mode;
      int  run_len;
      bit  dense;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  set_mode(1'b0, 1'b0); end
            1: begin tx_idle_pct = 74; rx_stall_pct = 0;  set_mode(1'b1, 1'b0); end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 74; set_mode(1'b1, 1'b1); end
            default: begin tx_idle_pct = 12; rx_stall_pct = 12; set_mode(1'b0, 1'b1); end
         endcase
         sent       = 0;
         since_mode = 0;
         while (sent < 300) begin
            dense   = ($urandom_range(99) < 12);
            run_len = dense ? $urandom_range(130, 200) : $urandom_range(1, 60);
            send_random_run(run_len, dense, $urandom_range(3) != 0);
            sent       += run_len;
            since_mode += run_len;
            if (since_mode >= 120) begin
               set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
               since_mode = 0;
            end
         end
      end
   endtask

   // Output held off for a long stretch while items keep coming
   task automatic test_output_holdoff();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      set_mode(1'b0, 1'b0);
      hold_len = HOLD_CYCLES;
      hold_seq++;
      send_random_run(40, 1'b0, 1'b1);
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = sps_pkg::CSR_KEY_MODE;
      csr_wdata         = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.data       = '0;
      rsp_ch.ready      = 1'b0;
      tx_idle_pct       = 0;
      rx_stall_pct      = 0;
      hold_len          = 0;
      hold_seq          = 0;
      fault_count       = 0;
      quiet_cycles      = 0;
      cfg_key_mode      = 1'b0;
      cfg_clear_history = 1'b0;
      clear_run_state();

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_count_saturation();
      test_random_runs();
      test_output_holdoff();

      drain_tracker();
      repeat (10) @(posedge clock);
      if (fault_count == 0 && seed_results_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
